### sv/rpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants for the rectangular/polar converter.
// ---------------------------------------------------------------------------
package rpc_pkg;

    localparam int TblLen = 32;
    localparam int DefStages = 20;

    typedef enum logic [1:0] {
        FORM_RECT  = 2'd0,
        FORM_POLAR = 2'd1,
        FORM_BAD2  = 2'd2,
        FORM_BAD3  = 2'd3
    } t_form;

    localparam logic signed [63:0] GainQ30     = 64'sd652032874;
    localparam logic signed [63:0] Deg2RadQ32  = 64'sd74961321;
    localparam logic signed [63:0] PiQ30       = 64'sd3373259426;
    localparam logic signed [63:0] FullTurn    = 64'sd23592960;
    localparam logic signed [63:0] HalfTurn    = 64'sd11796480;
    localparam logic signed [63:0] QuarterTurn = 64'sd5898240;

    function automatic logic signed [63:0] atan_q30(input int i);
        logic signed [63:0] v;
        case (i)
            0: v = 64'sh3243F6A8;  1: v = 64'sh1DAC6705;  2: v = 64'sh0FADBAFC;
            3: v = 64'sh07F56EA6;  4: v = 64'sh03FEAB76;  5: v = 64'sh01FFD55B;
            6: v = 64'sh00FFFAAA;  7: v = 64'sh007FFF55;  8: v = 64'sh003FFFEA;
            9: v = 64'sh001FFFFD;  10: v = 64'sh000FFFFF; 11: v = 64'sh0007FFFF;
            12: v = 64'sh0003FFFF; 13: v = 64'sh0001FFFF; 14: v = 64'sh0000FFFF;
            15: v = 64'sh00007FFF; 16: v = 64'sh00003FFF; 17: v = 64'sh00001FFF;
            18: v = 64'sh00000FFF; 19: v = 64'sh000007FF; 20: v = 64'sh000003FF;
            21: v = 64'sh000001FF; 22: v = 64'sh000000FF; 23: v = 64'sh0000007F;
            24: v = 64'sh0000003F; 25: v = 64'sh0000001F; 26: v = 64'sh0000000F;
            27: v = 64'sh00000008; 28: v = 64'sh00000004; 29: v = 64'sh00000002;
            30: v = 64'sh00000001;
            default: v = 64'sh0;
        endcase
        return v;
    endfunction

endpackage

### sv/rect_polar_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rect_polar_converter
// Pipelined CORDIC conversion between rectangular and polar Q16.16 vectors.
// ---------------------------------------------------------------------------
// Usage:
//   Input transaction (i_req_type, i_first_value, i_second_value) is taken
//   when i_valid and o_ready are high. Rectangular form returns x, y,
//   rounded sqrt magnitude and atan2 angle; polar form returns cos/sin
//   products and the angle in radians; other forms give zeros and
//   o_bad_form.
//   One transaction per cycle while the output is not stalled. There are
//   CORDIC_STAGES + 4 register stages (CORDIC_STAGES capped at TblLen):
//   a front stage, an angle reduction stage, one stage per CORDIC
//   iteration (shared by vectoring and rotation datapaths), a product stage
//   and the output register. The magnitude square root runs
//   ceil(32 / CORDIC_STAGES) result bits per stage alongside, finishing
//   within the same depth.
//   The whole pipeline advances only when the output register is empty or
//   being drained, so a stalled receiver holds every stage with nothing
//   lost; o_ready drops whenever a result waits and i_ready is low.
//   Reset clears all stage valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module rect_polar_converter #(
    parameter int CORDIC_STAGES = rpc_pkg::DefStages
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [1:0]         i_req_type,
    input  wire  signed [31:0] i_first_value,
    input  wire  signed [31:0] i_second_value,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_x_coord,
    output logic signed [31:0] o_y_coord,
    output logic signed [32:0] o_magnitude,
    output logic signed [26:0] o_angle_rad,
    output logic               o_bad_form
);
    import rpc_pkg::*;

    localparam int N  = (CORDIC_STAGES > TblLen) ? TblLen : CORDIC_STAGES;
    localparam int SQ = 32;             // sqrt result bits (64-bit radicand)

    // whole-degree reduction mod 360: bias keeps the count positive
    localparam logic [16:0] DegBias = 17'd33120;   // 92 turns
    localparam logic [15:0] Inv360  = 16'd46604;   // ceil(2^24 / 360)

    // advance when output slot is empty or being drained
    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // ---------------- stage 0: decode, squares, degree reduction, degree to radian product
    logic               r0_v;
    t_form              r0_form;
    logic signed [31:0] r0_a, r0_b;
    logic        [63:0] r0_sq;
    logic signed [63:0] r0_angp;   // b * Deg2Rad
    logic signed [63:0] r0_rem;    // b mod full turn

    logic [31:0] ua, ub;
    logic signed [63:0] rm;
    logic signed [15:0] dh;
    logic [16:0] dpos;
    logic [32:0] dq_p;
    logic [8:0]  dmod;
    assign ua = i_first_value[31]  ? 32'(-i_first_value)  : i_first_value;
    assign ub = i_second_value[31] ? 32'(-i_second_value) : i_second_value;
    // floor mod of the Q16.16 degrees: reduce the integer part, keep fraction
    assign dh   = i_second_value[31:16];
    assign dpos = 17'(dh) + DegBias;
    assign dq_p = 33'(dpos) * 33'(Inv360);
    assign dmod = 9'(dpos - 17'(dq_p[32:24]) * 17'd360);
    assign rm   = 64'({dmod, i_second_value[15:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (adv) begin
            r0_v <= i_valid;
        end
        if (adv) begin
            r0_form <= t_form'(i_req_type);
            r0_a    <= i_first_value;
            r0_b    <= i_second_value;
            r0_sq   <= 64'(ua) * 64'(ua) + 64'(ub) * 64'(ub);
            r0_angp <= 64'(i_second_value) * Deg2RadQ32;
            r0_rem  <= rm;
        end
    end

    // ---------------- stage 1: fold, CORDIC seed
    typedef struct packed {
        logic               v;
        t_form              form;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [26:0] ang_pol;
        logic               flip;
        logic               zero;
        logic signed [63:0] x, y, z;
        logic        [63:0] s_rem, s_res;
    } t_stage;

    t_stage r_st [N+1];
    t_stage seed;
    logic signed [63:0] rr, zz;

    always_comb begin
        seed       = '0;
        zz         = '0;
        seed.v     = r0_v;
        seed.form  = r0_form;
        seed.a     = r0_a;
        seed.b     = r0_b;
        seed.ang_pol = 27'((r0_angp + (64'sd1 <<< 31)) >>> 32);
        seed.zero  = (r0_a == 0) && (r0_b == 0);
        seed.s_rem = r0_sq;
        seed.s_res = '0;
        rr = r0_rem;
        if (rr >= HalfTurn) rr = rr - FullTurn;
        if (rr > QuarterTurn) begin
            rr = rr - HalfTurn; seed.flip = 1'b1;
        end else if (rr < -QuarterTurn) begin
            rr = rr + HalfTurn; seed.flip = 1'b1;
        end
        if (r0_form == FORM_POLAR) begin
            seed.x = GainQ30;
            seed.y = '0;
            seed.z = (rr * Deg2RadQ32 + (64'sd1 <<< 17)) >>> 18;
        end else begin
            seed.x = 64'(r0_a);
            seed.y = 64'(r0_b);
            if (r0_a < 0) begin
                zz = (r0_b >= 0) ? PiQ30 : -PiQ30;
                seed.x = -64'(r0_a);
                seed.y = -64'(r0_b);
            end
            seed.x = seed.x <<< 28;
            seed.y = seed.y <<< 28;
            seed.z = zz;
        end
    end

    // sqrt: 32 digit steps spread over the CORDIC stages
    localparam int SqPer = (SQ + N - 1) / N;

    function automatic void sq_step(input int k, inout logic [63:0] rem,
                                    inout logic [63:0] res);
        logic [63:0] b, t;
        b = 64'd1 << (62 - 2 * k);
        t = res + b;
        if (rem >= t) begin
            rem = rem - t;
            res = (res >> 1) + b;
        end else begin
            res = res >> 1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].v <= 1'b0;
        end else if (adv) begin
            r_st[0].v <= seed.v;
        end
        if (adv) r_st[0][$bits(t_stage)-2:0] <= seed[$bits(t_stage)-2:0];
    end

    for (genvar g = 0; g < N; g++) begin : g_cordic
        t_stage nx;
        logic [63:0] rem, res;
        always_comb begin
            nx = r_st[g];
            if (r_st[g].form == FORM_POLAR) begin
                if (r_st[g].z >= 0) begin
                    nx.x = r_st[g].x - (r_st[g].y >>> g);
                    nx.y = r_st[g].y + (r_st[g].x >>> g);
                    nx.z = r_st[g].z - atan_q30(g);
                end else begin
                    nx.x = r_st[g].x + (r_st[g].y >>> g);
                    nx.y = r_st[g].y - (r_st[g].x >>> g);
                    nx.z = r_st[g].z + atan_q30(g);
                end
            end else begin
                if (r_st[g].y >= 0) begin
                    nx.x = r_st[g].x + (r_st[g].y >>> g);
                    nx.y = r_st[g].y - (r_st[g].x >>> g);
                    nx.z = r_st[g].z + atan_q30(g);
                end else begin
                    nx.x = r_st[g].x - (r_st[g].y >>> g);
                    nx.y = r_st[g].y + (r_st[g].x >>> g);
                    nx.z = r_st[g].z - atan_q30(g);
                end
            end
            rem = r_st[g].s_rem;
            res = r_st[g].s_res;
            for (int k = g * SqPer; k < (g + 1) * SqPer; k++) begin
                if (k < SQ) sq_step(k, rem, res);
            end
            nx.s_rem = rem;
            nx.s_res = res;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g+1].v <= 1'b0;
            end else if (adv) begin
                r_st[g+1].v <= nx.v;
            end
            if (adv) r_st[g+1][$bits(t_stage)-2:0] <= nx[$bits(t_stage)-2:0];
        end
    end

    // ---------------- product stage
    t_stage fin;
    assign fin = r_st[N];
    // cos/sin scaled 2^30 fit comfortably in 32 bits
    logic signed [31:0] cc, ss;
    logic signed [63:0] r_px, r_py;
    logic r_pv;
    t_stage r_pf;
    assign cc = 32'(fin.flip ? -fin.x : fin.x);
    assign ss = 32'(fin.flip ? -fin.y : fin.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= fin.v;
        end
        if (adv) begin
            r_pf <= fin;
            r_px <= 64'(fin.a) * 64'(cc);
            r_py <= 64'(fin.a) * 64'(ss);
        end
    end

    // ---------------- output register
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    logic signed [63:0] rx, ry;
    logic [63:0] mq;
    assign rx = (r_px + (64'sd1 <<< 29)) >>> 30;
    assign ry = (r_py + (64'sd1 <<< 29)) >>> 30;
    assign mq = (r_pf.s_rem > r_pf.s_res) ? r_pf.s_res + 64'd1 : r_pf.s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_pv;
        end
        if (adv) begin
            unique case (r_pf.form)
                FORM_RECT: begin
                    o_x_coord   <= r_pf.a;
                    o_y_coord   <= r_pf.b;
                    o_magnitude <= 33'(mq);
                    o_angle_rad <= r_pf.zero ? '0 :
                                   27'((r_pf.z + (64'sd1 <<< 13)) >>> 14);
                    o_bad_form  <= 1'b0;
                end
                FORM_POLAR: begin
                    o_x_coord   <= sat32(rx);
                    o_y_coord   <= sat32(ry);
                    o_magnitude <= 33'(r_pf.a);
                    o_angle_rad <= r_pf.ang_pol;
                    o_bad_form  <= 1'b0;
                end
                default: begin
                    o_x_coord   <= '0;
                    o_y_coord   <= '0;
                    o_magnitude <= '0;
                    o_angle_rad <= '0;
                    o_bad_form  <= 1'b1;
                end
            endcase
        end
    end

    // ---------------- assertions
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("ready high while output stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped under stall");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_form) |-> (o_magnitude == 0 && o_angle_rad == 0))
        else $error("invalid form with nonzero result");

endmodule
`default_nettype wire
